// ===== rtl/core/hcrc_pkg.sv =====
// shared types, constants and the crc byte update for the component header crc checker
`timescale 1ns / 1ps

package hcrc_pkg;

   // number of data bytes the crc covers at most
   localparam int unsigned COVER_MAX = 13;

   // byte position counter reaches 4 + COVER_MAX
   localparam int unsigned POS_W   = $clog2(COVER_MAX + 5);
   // covered byte count reaches COVER_MAX
   localparam int unsigned COVER_W = $clog2(COVER_MAX + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_XOR  = 16'hFFFF;

   // header byte positions (index of the next byte)
   localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(4);
   localparam logic [POS_W-1:0] POS_DATA   = POS_W'(5);
   // offset of the first data byte minus one
   localparam logic [POS_W-1:0] HDR_BYTES  = POS_W'(4);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } hcrc_item_type;

   typedef struct packed {
      logic        crc_ok;
      logic        length_invalid;
      logic [7:0]  component_id;
      logic [15:0] field_length;
   } hcrc_verdict_type;

   // byte-wise crc-16 update, polynomial 0x1021, msb first
   function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = {c[7:0], c[15:8]} ^ {8'h00, b};
      x = x ^ {12'h000, x[7:4]};
      x = x ^ ({x[3:0], 12'h000} ^ {3'b000, x[7:0], 5'b00000});
      return x;
   endfunction

   // number of covered data bytes for a given length field
   function automatic logic [COVER_W-1:0] cover_size(input logic [15:0] len);
      logic [COVER_W-1:0] size;
      if (len < 16'(COVER_MAX)) begin
         size = len[COVER_W-1:0];
      end else begin
         size = COVER_W'(COVER_MAX);
      end
      return size;
   endfunction

endpackage

// ===== rtl/core/hcrc_if.sv =====
// item channel interfaces for the component header crc checker
`timescale 1ns / 1ps

interface hcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;

   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface hcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        crc_ok;
   logic        length_invalid;
   logic [7:0]  component_id;
   logic [15:0] field_length;

   modport source (output valid, output crc_ok, output length_invalid,
                   output component_id, output field_length, input ready);
   modport sink   (input valid, input crc_ok, input length_invalid,
                   input component_id, input field_length, output ready);
endinterface

// ===== rtl/core/hcrc_frame_tracker.sv =====
// frame header tracking and running crc for one byte per step
`timescale 1ns / 1ps

module hcrc_frame_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  hcrc_pkg::hcrc_item_type   item,
   output logic                      emit,
   output hcrc_pkg::hcrc_verdict_type verdict
);

   logic [15:0]                crc_ff, crc_in;
   logic [hcrc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [15:0]                stored_ff, stored_in;
   logic [15:0]                length_ff, length_in;
   logic [7:0]                 id_ff, id_in;
   logic                       done_ff, done_in;
   logic                       invalid;
   logic [15:0]                crc_step;

   assign crc_step = hcrc_pkg::crc_feed(crc_ff, item.data_byte);

   // next state for one byte
   always_comb begin
      crc_in    = crc_ff;
      pos_in    = pos_ff;
      stored_in = stored_ff;
      length_in = length_ff;
      id_in     = id_ff;
      done_in   = done_ff;
      emit      = 1'b0;
      invalid   = 1'b0;
      if (item.first_byte) begin
         crc_in    = hcrc_pkg::crc_feed(hcrc_pkg::CRC_INIT, item.data_byte);
         id_in     = item.data_byte;
         length_in = 16'h0000;
         stored_in = 16'h0000;
         pos_in    = hcrc_pkg::POS_LEN_HI;
         done_in   = 1'b0;
      end else if (!done_ff) begin
         case (pos_ff)
            hcrc_pkg::POS_LEN_HI: begin
               crc_in    = crc_step;
               length_in = {item.data_byte, 8'h00};
               pos_in    = hcrc_pkg::POS_LEN_LO;
            end
            hcrc_pkg::POS_LEN_LO: begin
               crc_in    = crc_step;
               length_in = {length_ff[15:8], item.data_byte};
               if (length_ff[15]) begin
                  emit    = 1'b1;
                  invalid = 1'b1;
               end else begin
                  pos_in = hcrc_pkg::POS_CRC_HI;
               end
            end
            hcrc_pkg::POS_CRC_HI: begin
               stored_in = {item.data_byte, 8'h00};
               pos_in    = hcrc_pkg::POS_CRC_LO;
            end
            hcrc_pkg::POS_CRC_LO: begin
               stored_in = {stored_ff[15:8], item.data_byte};
               if (hcrc_pkg::cover_size(length_ff) == '0) begin
                  emit = 1'b1;
               end else begin
                  pos_in = hcrc_pkg::POS_DATA;
               end
            end
            default: begin
               // covered data bytes
               crc_in = crc_step;
               if ((pos_ff - hcrc_pkg::HDR_BYTES)
                   >= hcrc_pkg::POS_W'(hcrc_pkg::cover_size(length_ff))) begin
                  emit = 1'b1;
               end else begin
                  pos_in = pos_ff + hcrc_pkg::POS_W'(1);
               end
            end
         endcase
         if (emit) begin
            done_in = 1'b1;
         end
      end
   end

   // verdict from the updated state
   always_comb begin
      verdict.length_invalid = invalid;
      verdict.crc_ok         = !invalid && ((crc_in ^ hcrc_pkg::CRC_XOR) == stored_in);
      verdict.component_id   = id_in;
      verdict.field_length   = length_in;
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= hcrc_pkg::CRC_INIT;
         pos_ff    <= '0;
         stored_ff <= 16'h0000;
         length_ff <= 16'h0000;
         id_ff     <= 8'h00;
         done_ff   <= 1'b1;
      end else if (step_en) begin
         crc_ff    <= crc_in;
         pos_ff    <= pos_in;
         stored_ff <= stored_in;
         length_ff <= length_in;
         id_ff     <= id_in;
         done_ff   <= done_in;
      end
   end

endmodule

// ===== rtl/core/component_header_crc_checker_core.sv =====
// top level of the component header crc checker
`timescale 1ns / 1ps

// channel   role    payload                                              handshake
// req_chan  sink    data_byte[7:0], first_byte                           valid/ready
// rsp_chan  source  crc_ok, length_invalid, component_id[7:0],           valid/ready
//                   field_length[15:0]
//
// one byte per cycle sustained while the result register is free; a byte passes an input
// register, one crc byte update and the result register, where the verdict of its frame
// waits until the receiver takes it.
// synchronous reset empties both registers and leaves the tracker idle until a start.
// a stalled result holds the next byte in the input register; input stalls cost nothing.

module component_header_crc_checker_core (
   input  logic    clock,
   input  logic    reset,
   hcrc_req_if.sink   req_chan,
   hcrc_rsp_if.source rsp_chan
);

   logic                       in_valid_ff, in_valid_in;
   hcrc_pkg::hcrc_item_type    in_item_ff;
   logic                       out_valid_ff, out_valid_in;
   hcrc_pkg::hcrc_verdict_type out_ff;
   hcrc_pkg::hcrc_verdict_type verdict;
   logic                       out_free;
   logic                       step_en;
   logic                       emit;

   // an item is worked on when the result register can take its verdict
   assign out_free      = !out_valid_ff || rsp_chan.ready;
   assign step_en       = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || step_en;

   hcrc_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .emit    (emit),
      .verdict (verdict)
   );

   // register occupancy
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_en && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.data_byte  <= req_chan.data_byte;
         in_item_ff.first_byte <= req_chan.first_byte;
      end
      if (step_en && emit) begin
         out_ff <= verdict;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.crc_ok         = out_ff.crc_ok;
   assign rsp_chan.length_invalid = out_ff.length_invalid;
   assign rsp_chan.component_id   = out_ff.component_id;
   assign rsp_chan.field_length   = out_ff.field_length;

   // an invalid length never passes the crc check
   a_invalid_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.crc_ok && rsp_chan.length_invalid))
      else $error("invalid length reported with crc ok");

   // invalid flag only with the length top bit set
   a_invalid_top_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.length_invalid) |-> rsp_chan.field_length[15])
      else $error("invalid length without top bit");

   // an empty input register always takes a byte
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_chan.ready)
      else $error("input register empty but not ready");

   // no verdict directly after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule

// ===== verif/tb_component_header_crc_checker_core.sv =====
// testbench for the component header crc checker: framed byte streams against predicted verdicts
`timescale 1ns / 1ps

module tb_component_header_crc_checker_core;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 8;

   logic clock;
   logic reset;

   hcrc_req_if req_bus ();
   hcrc_rsp_if rsp_bus ();

   component_header_crc_checker_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // handshake pressure in percent
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // run statistics
   int fail_count     = 0;
   int sent_bytes     = 0;
   int framed_bytes   = 0;
   int verdict_count  = 0;
   int good_count     = 0;
   int invalid_count  = 0;
   int restart_count  = 0;
   int quiet_cycles   = 0;

   // expected verdicts, oldest first
   hcrc_pkg::hcrc_verdict_type verdict_q[$];
   hcrc_pkg::hcrc_verdict_type want;

   // frame tracker state
   logic [15:0]                run_crc   = hcrc_pkg::CRC_INIT;
   logic [15:0]                held_crc  = '0;
   logic [15:0]                len_field = '0;
   logic [7:0]                 frame_id  = '0;
   logic [hcrc_pkg::POS_W-1:0] next_pos  = '0;
   bit                         frame_idle = 1'b1;

   // clock
   always #5 clock = ~clock;

   // crc-16 over one byte, bit at a time, msb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
      end
      return r;
   endfunction

   // data bytes that the crc covers for a length field
   function automatic int cover_count(input logic [15:0] len);
      return (len < 16'(hcrc_pkg::COVER_MAX)) ? int'(len) : int'(hcrc_pkg::COVER_MAX);
   endfunction

   // queue the verdict of the current frame and go idle
   function automatic void post_verdict(input bit bad_len);
      hcrc_pkg::hcrc_verdict_type v;
      v.crc_ok         = !bad_len && ((run_crc ^ hcrc_pkg::CRC_XOR) == held_crc);
      v.length_invalid = bad_len;
      v.component_id   = frame_id;
      v.field_length   = len_field;
      verdict_q.push_back(v);
      frame_idle = 1'b1;
   endfunction

   // advance the frame tracker by one accepted byte; 0 when the byte is ignored
   function automatic bit track_byte(input logic [7:0] b, input logic s);
      if (s) begin
         if (!frame_idle) restart_count++;
         run_crc    = crc16_byte(hcrc_pkg::CRC_INIT, b);
         frame_id   = b;
         len_field  = '0;
         held_crc   = '0;
         next_pos   = hcrc_pkg::POS_LEN_HI;
         frame_idle = 1'b0;
         return 1'b1;
      end
      if (frame_idle) return 1'b0;
      case (next_pos)
         hcrc_pkg::POS_LEN_HI: begin
            run_crc   = crc16_byte(run_crc, b);
            len_field = {b, 8'h00};
            next_pos  = hcrc_pkg::POS_LEN_LO;
         end
         hcrc_pkg::POS_LEN_LO: begin
            run_crc        = crc16_byte(run_crc, b);
            len_field[7:0] = b;
            if (len_field[15]) post_verdict(1'b1);
            else next_pos = hcrc_pkg::POS_CRC_HI;
         end
         hcrc_pkg::POS_CRC_HI: begin
            held_crc[15:8] = b;
            next_pos       = hcrc_pkg::POS_CRC_LO;
         end
         hcrc_pkg::POS_CRC_LO: begin
            held_crc[7:0] = b;
            if (cover_count(len_field) == 0) post_verdict(1'b0);
            else next_pos = hcrc_pkg::POS_DATA;
         end
         default: begin
            run_crc = crc16_byte(run_crc, b);
            if (int'(next_pos) - int'(hcrc_pkg::HDR_BYTES) >= cover_count(len_field))
               post_verdict(1'b0);
            else next_pos = next_pos + 1'b1;
         end
      endcase
      return 1'b1;
   endfunction

   // send one item, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b, input logic s);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.first_byte <= s;
      do @(posedge clock); while (!req_bus.ready);
      sent_bytes++;
      if (track_byte(b, s)) framed_bytes++;
   endtask

   // build a frame with random data and send it, possibly cut short
   task automatic send_frame(input logic [7:0] id, input logic [15:0] len, input bit crc_good,
                             input int extra, input int cut);
      logic [7:0]  frame_q[$];
      logic [7:0]  b;
      logic [15:0] crc;
      int          total;
      frame_q.push_back(id);
      frame_q.push_back(len[15:8]);
      frame_q.push_back(len[7:0]);
      crc = crc16_byte(crc16_byte(crc16_byte(hcrc_pkg::CRC_INIT, id), len[15:8]), len[7:0]);
      if (!len[15]) begin
         // stored crc bytes filled in once the data are known
         frame_q.push_back(8'h00);
         frame_q.push_back(8'h00);
         repeat (cover_count(len)) begin
            b   = 8'($urandom);
            crc = crc16_byte(crc, b);
            frame_q.push_back(b);
         end
         crc = crc ^ hcrc_pkg::CRC_XOR;
         if (!crc_good) crc = crc ^ 16'($urandom_range(16'hFFFF, 1));
         frame_q[3] = crc[15:8];
         frame_q[4] = crc[7:0];
      end
      repeat (extra) frame_q.push_back(8'($urandom));
      total = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
      for (int i = 0; i < total; i++) send_byte(frame_q[i], i == 0);
   endtask

   // bytes after reset with no start are dropped
   task automatic test_ignored_bytes();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // zero length: verdict on the stored crc low byte
   task automatic test_zero_length();
      send_frame(8'hFF, 16'h0000, 1'b1, 0, 0);
   endtask

   // top bit of the length set: early invalid verdict, trailing bytes ignored
   task automatic test_length_invalid();
      send_frame(8'h00, 16'hFFFF, 1'b0, 1, 0);
      send_frame(8'h80, 16'h8000, 1'b1, 0, 0);
   endtask

   // a start in the middle of a frame drops it; the new frame carries a bad crc
   task automatic test_restart();
      send_frame(8'h5A, 16'h0005, 1'b1, 0, 2);
      send_frame(8'hA5, 16'h0001, 1'b0, 0, 0);
   endtask

   // mostly well-formed frames with random content, some cut short, some noise
   task automatic test_random_traffic(input int goal);
      int          first_count;
      int          pick;
      logic [15:0] len;
      first_count = sent_bytes;
      while (sent_bytes - first_count < goal) begin
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom), $urandom_range(9, 0) == 0);
         end else begin
            pick = $urandom_range(99, 0);
            if (pick < 70) len = 16'($urandom_range(hcrc_pkg::COVER_MAX + 2, 0));
            else if (pick < 85)
               len = 16'($urandom_range(16'h7FFF, hcrc_pkg::COVER_MAX + 3));
            else len = 16'($urandom_range(16'hFFFF, 16'h8000));
            send_frame(8'($urandom), len, $urandom_range(99, 0) < 75, $urandom_range(2, 0),
                       ($urandom_range(99, 0) < 10) ? $urandom_range(17, 1) : 0);
         end
      end
   endtask

   // compare one field of a verdict
   function automatic void check_field(input string what, input logic [15:0] exp_val,
                                       input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s wrong, expected %0h, actual %0h", $time, what, exp_val, act_val);
         fail_count++;
      end
   endfunction

   // check each verdict against the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: verdict with none expected, expected nothing, actual %0h %0h %0h %0h",
                     $time, rsp_bus.crc_ok, rsp_bus.length_invalid, rsp_bus.component_id,
                     rsp_bus.field_length);
            fail_count++;
         end else begin
            want = verdict_q.pop_front();
            check_field("crc_ok", 16'(want.crc_ok), 16'(rsp_bus.crc_ok));
            check_field("length_invalid", 16'(want.length_invalid), 16'(rsp_bus.length_invalid));
            check_field("component_id", 16'(want.component_id), 16'(rsp_bus.component_id));
            check_field("field_length", want.field_length, rsp_bus.field_length);
            verdict_count++;
            if (want.crc_ok) good_count++;
            if (want.length_invalid) invalid_count++;
         end
      end
   end

   // random receiver stalls
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // watchdog on cycles where no item moves on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no item moved for %0d cycles, %0d verdicts outstanding",
                  $time, quiet_cycles, verdict_q.size());
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = 8'h00;
      req_bus.first_byte = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_ignored_bytes();
      test_zero_length();
      test_length_invalid();
      test_restart();

      test_random_traffic(175);
      send_idle_pct  = 84;
      test_random_traffic(175);
      send_idle_pct  = 0;
      recv_stall_pct = 84;
      test_random_traffic(175);
      send_idle_pct  = 35;
      recv_stall_pct = 35;
      test_random_traffic(175);

      // drain
      @(negedge clock);
      req_bus.valid  <= 1'b0;
      recv_stall_pct = 0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d bytes sent, %0d inside frames, %0d frames dropped by a restart",
               sent_bytes, framed_bytes, restart_count);
      $display("Verdicts checked: %0d, with %0d crc good and %0d length invalid",
               verdict_count, good_count, invalid_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
